// ----- src/tss_pkg.sv -----
`default_nettype none
package tss_pkg;
	localparam int MaxSegments = 8;
	localparam int EventsPerSegment = 4;
	localparam int SegW = 4;
	localparam int EvW = 2;
	localparam int CntW = 3;
	localparam int SlotW = 5;
	localparam logic [31:0] MinDurationUs = 32'd1000;

	localparam logic [2:0] OP_ADD_SEG = 3'd0;
	localparam logic [2:0] OP_ADD_EVT = 3'd1;
	localparam logic [2:0] OP_PLAY = 3'd2;
	localparam logic [2:0] OP_STOP = 3'd3;
	localparam logic [2:0] OP_SKIP = 3'd4;
	localparam logic [2:0] OP_TICK = 3'd5;

	localparam logic [2:0] KIND_CHANGED = 3'd0;
	localparam logic [2:0] KIND_FIRED = 3'd1;
	localparam logic [2:0] KIND_COMPLETE = 3'd2;
	localparam logic [2:0] KIND_REJECTED = 3'd3;
	localparam logic [2:0] KIND_STATUS = 3'd4;

	typedef struct packed {
		logic [2:0] operation;
		logic [31:0] time_value;
		logic signed [7:0] target_index;
		logic [15:0] event_tag;
	} in_item_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [3:0] changed_index;
		logic [15:0] fired_tag;
		logic [3:0] segment_now;
		logic [31:0] time_in_segment;
		logic is_playing;
		logic is_complete;
		logic last;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_INS_SCAN,
		ST_INS_SHIFT,
		ST_FIRE_RD,
		ST_FIRE_CHK,
		ST_ADV,
		ST_EMIT,
		ST_STATUS
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load_item;
		logic add_seg;
		logic add_evt_begin;
		logic ins_step;
		logic ins_shift;
		logic play;
		logic stop;
		logic skip;
		logic tick_begin;
		logic fire_rd;
		logic fire_mark;
		logic adv;
		logic emit;
		logic [2:0] emit_kind;
		logic emit_last;
		logic emit_chg;
		logic emit_tag;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic [2:0] op;
		logic seg_full;
		logic evt_reject;
		logic seg_empty;
		logic tick_idle;
		logic tick_past;
		logic ins_done;
		logic shift_done;
		logic fire_done;
		logic fire_hit;
		logic adv_wrap;
		logic adv_end;
		logic out_busy;
	} sts_t;
endpackage
`default_nettype wire

// ----- src/tss_datapath.sv -----
`default_nettype none
module tss_datapath (
	input wire logic clk,
	input wire logic arst_n,
	input wire tss_pkg::in_item_t in_item,
	input wire tss_pkg::cmd_t cmd,
	output tss_pkg::sts_t sts,
	output tss_pkg::out_item_t result,
	output logic result_valid,
	input wire logic result_ready
);
	logic [31:0] dur_mem [tss_pkg::MaxSegments];
	logic [31:0] evt_time_mem [tss_pkg::MaxSegments*tss_pkg::EventsPerSegment];
	logic [15:0] evt_tag_mem [tss_pkg::MaxSegments*tss_pkg::EventsPerSegment];
	logic [tss_pkg::MaxSegments*tss_pkg::EventsPerSegment-1:0] fired_q;
	logic [tss_pkg::CntW-1:0] n_evt_q [tss_pkg::MaxSegments];
	logic [tss_pkg::SegW-1:0] seg_cnt_q, cur_q;
	logic [31:0] time_q;
	logic playing_q, complete_q;
	tss_pkg::in_item_t item_q;
	logic [31:0] ev_t_q;
	logic [tss_pkg::CntW-1:0] pos_q;
	logic [tss_pkg::CntW-1:0] idx_q;
	logic [31:0] rd_time_q;
	logic [15:0] rd_tag_q;
	logic [15:0] tag_q;
	logic [tss_pkg::SegW-1:0] chg_q;
	logic [31:0] dur_rd_q;
	tss_pkg::out_item_t res_q;
	logic res_v_q;

	logic [tss_pkg::CntW-1:0] last_n;
	logic [tss_pkg::SlotW-1:0] slot_ins, slot_rd, slot_src, slot_dst;
	logic [32:0] sum;
	logic [31:0] clamp_t;
	logic [tss_pkg::SegW-1:0] skip_idx;
	logic [2:0] cur_seg;

	assign cur_seg = cur_q[2:0];
	assign last_n = n_evt_q[seg_cnt_q[2:0] - 3'd1];
	assign slot_ins = {seg_cnt_q[2:0] - 3'd1, pos_q[1:0]};
	assign slot_dst = {seg_cnt_q[2:0] - 3'd1, idx_q[1:0]};
	assign slot_src = {seg_cnt_q[2:0] - 3'd1, idx_q[1:0] - 2'd1};
	assign slot_rd = {cur_seg, idx_q[1:0]};
	assign sum = {1'b0, time_q} + {1'b0, item_q.time_value};
	assign clamp_t = (item_q.time_value > dur_mem[seg_cnt_q[2:0] - 3'd1]) ?
		dur_mem[seg_cnt_q[2:0] - 3'd1] : item_q.time_value;

	always_comb begin
		if (item_q.target_index[7])
			skip_idx = '0;
		else if ({1'b0, item_q.target_index[6:0]} > {4'd0, seg_cnt_q - 4'd1})
			skip_idx = seg_cnt_q - 4'd1;
		else
			skip_idx = item_q.target_index[3:0];
	end

	always_comb begin
		sts.op = item_q.operation;
		sts.seg_full = seg_cnt_q >= 4'(tss_pkg::MaxSegments);
		sts.evt_reject = (seg_cnt_q == '0) ||
			(last_n >= 3'(tss_pkg::EventsPerSegment));
		sts.seg_empty = seg_cnt_q == '0;
		sts.tick_idle = !playing_q || complete_q;
		sts.tick_past = cur_q >= seg_cnt_q;
		sts.ins_done = (pos_q >= last_n) ||
			(evt_time_mem[slot_ins] >= ev_t_q);
		sts.shift_done = idx_q <= pos_q;
		sts.fire_done = idx_q >= n_evt_q[cur_seg];
		sts.fire_hit = !fired_q[slot_rd] && (time_q >= rd_time_q);
		sts.adv_wrap = time_q >= dur_rd_q;
		sts.adv_end = (cur_q + 4'd1) >= seg_cnt_q;
		sts.out_busy = res_v_q && !result_ready;
	end

	// storage writes (no reset)
	always_ff @(posedge clk) begin
		if (cmd.add_seg && !sts.seg_full)
			dur_mem[seg_cnt_q[2:0]] <= (item_q.time_value == '0) ?
				tss_pkg::MinDurationUs : item_q.time_value;
		if (cmd.ins_shift) begin
			if (idx_q > pos_q) begin
				evt_time_mem[slot_dst] <= evt_time_mem[slot_src];
				evt_tag_mem[slot_dst] <= evt_tag_mem[slot_src];
			end else begin
				evt_time_mem[slot_ins] <= ev_t_q;
				evt_tag_mem[slot_ins] <= item_q.event_tag;
			end
		end
		if (cmd.fire_rd) begin
			rd_time_q <= evt_time_mem[slot_rd];
			rd_tag_q <= evt_tag_mem[slot_rd];
		end
		dur_rd_q <= dur_mem[cur_seg];
		if (cmd.load_item)
			item_q <= in_item;
		if (cmd.add_evt_begin)
			ev_t_q <= clamp_t;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fired_q <= '0;
			for (int s = 0; s < tss_pkg::MaxSegments; s++)
				n_evt_q[s] <= '0;
			seg_cnt_q <= '0;
			cur_q <= '0;
			time_q <= '0;
			playing_q <= 1'b0;
			complete_q <= 1'b0;
			pos_q <= '0;
			idx_q <= '0;
			tag_q <= '0;
			chg_q <= '0;
			res_v_q <= 1'b0;
			res_q <= '0;
		end else begin
			if (cmd.emit)
				res_v_q <= 1'b1;
			else if (res_v_q && result_ready)
				res_v_q <= 1'b0;
			if (cmd.add_seg && !sts.seg_full) begin
				n_evt_q[seg_cnt_q[2:0]] <= '0;
				fired_q[{seg_cnt_q[2:0], 2'd0} +: tss_pkg::EventsPerSegment] <= '0;
				seg_cnt_q <= seg_cnt_q + 4'd1;
			end
			if (cmd.add_evt_begin)
				pos_q <= '0;
			if (cmd.ins_step) begin
				if (!sts.ins_done)
					pos_q <= pos_q + 3'd1;
				else
					idx_q <= last_n;
			end
			if (cmd.ins_shift) begin
				if (idx_q > pos_q) begin
					fired_q[slot_dst] <= fired_q[slot_src];
					idx_q <= idx_q - 3'd1;
				end else begin
					fired_q[slot_ins] <= 1'b0;
					n_evt_q[seg_cnt_q[2:0] - 3'd1] <= last_n + 3'd1;
				end
			end
			if (cmd.play) begin
				if (sts.seg_empty)
					complete_q <= 1'b1;
				else begin
					fired_q <= '0;
					cur_q <= '0;
					time_q <= '0;
					playing_q <= 1'b1;
					complete_q <= 1'b0;
				end
				chg_q <= '0;
			end
			if (cmd.stop)
				playing_q <= 1'b0;
			if (cmd.skip && !sts.seg_empty) begin
				cur_q <= skip_idx;
				chg_q <= skip_idx;
				time_q <= '0;
				playing_q <= 1'b1;
				complete_q <= 1'b0;
				fired_q[{skip_idx[2:0], 2'd0} +: tss_pkg::EventsPerSegment] <= '0;
			end
			if (cmd.tick_begin) begin
				if (sts.tick_past) begin
					complete_q <= 1'b1;
					playing_q <= 1'b0;
				end else
					time_q <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
				idx_q <= '0;
			end
			if (cmd.fire_mark) begin
				if (sts.fire_hit) begin
					fired_q[slot_rd] <= 1'b1;
					tag_q <= rd_tag_q;
				end
				idx_q <= idx_q + 3'd1;
			end
			if (cmd.adv) begin
				idx_q <= '0;
				cur_q <= cur_q + 4'd1;
				if (sts.adv_end) begin
					playing_q <= 1'b0;
					complete_q <= 1'b1;
					time_q <= '0;
				end else begin
					time_q <= time_q - dur_rd_q;
					chg_q <= cur_q + 4'd1;
					fired_q[{cur_seg + 3'd1, 2'd0} +: tss_pkg::EventsPerSegment] <= '0;
				end
			end
			if (cmd.emit) begin
				res_q.kind <= cmd.emit_kind;
				res_q.changed_index <= cmd.emit_chg ? chg_q : '0;
				res_q.fired_tag <= cmd.emit_tag ? tag_q : '0;
				res_q.segment_now <= cur_q;
				res_q.time_in_segment <= time_q;
				res_q.is_playing <= playing_q;
				res_q.is_complete <= complete_q;
				res_q.last <= cmd.emit_last;
			end
		end
	end

	assign result = res_q;
	assign result_valid = res_v_q;
endmodule
`default_nettype wire

// ----- src/tss_ctrl.sv -----
`default_nettype none
module tss_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire tss_pkg::sts_t sts,
	output tss_pkg::cmd_t cmd
);
	tss_pkg::state_t state_q, state_d;
	// pending emit and where to go after it
	logic [2:0] kind_q, kind_d;
	logic chg_q, chg_d, tagsel_q, tagsel_d;
	tss_pkg::state_t ret_q, ret_d;
	logic fire_sel_q, fire_sel_d; // fire walk after a segment change

	always_comb begin
		state_d = state_q;
		kind_d = kind_q;
		chg_d = chg_q;
		tagsel_d = tagsel_q;
		ret_d = ret_q;
		fire_sel_d = fire_sel_q;
		unique case (state_q)
			tss_pkg::ST_IDLE: begin
				if (in_valid)
					state_d = tss_pkg::ST_DECODE;
			end
			tss_pkg::ST_DECODE: begin
				state_d = tss_pkg::ST_STATUS;
				chg_d = 1'b0;
				tagsel_d = 1'b0;
				ret_d = tss_pkg::ST_STATUS;
				case (sts.op)
					tss_pkg::OP_ADD_SEG: begin
						if (sts.seg_full) begin
							kind_d = tss_pkg::KIND_REJECTED;
							state_d = tss_pkg::ST_EMIT;
						end
					end
					tss_pkg::OP_ADD_EVT: begin
						if (sts.evt_reject) begin
							kind_d = tss_pkg::KIND_REJECTED;
							state_d = tss_pkg::ST_EMIT;
						end else
							state_d = tss_pkg::ST_INS_SCAN;
					end
					tss_pkg::OP_PLAY: begin
						if (!sts.seg_empty) begin
							kind_d = tss_pkg::KIND_CHANGED;
							chg_d = 1'b1;
							state_d = tss_pkg::ST_EMIT;
						end
					end
					tss_pkg::OP_SKIP: begin
						if (!sts.seg_empty) begin
							kind_d = tss_pkg::KIND_CHANGED;
							chg_d = 1'b1;
							state_d = tss_pkg::ST_EMIT;
						end
					end
					tss_pkg::OP_TICK: begin
						if (!sts.tick_idle && !sts.tick_past) begin
							state_d = tss_pkg::ST_FIRE_RD;
							fire_sel_d = 1'b0;
						end
					end
					default: ;
				endcase
			end
			tss_pkg::ST_INS_SCAN: begin
				if (sts.ins_done)
					state_d = tss_pkg::ST_INS_SHIFT;
			end
			tss_pkg::ST_INS_SHIFT: begin
				if (sts.shift_done)
					state_d = tss_pkg::ST_STATUS;
			end
			tss_pkg::ST_FIRE_RD: begin
				if (sts.fire_done) begin
					if (fire_sel_q) begin
						kind_d = tss_pkg::KIND_CHANGED;
						chg_d = 1'b1;
						tagsel_d = 1'b0;
						ret_d = tss_pkg::ST_ADV;
						state_d = tss_pkg::ST_EMIT;
					end else
						state_d = tss_pkg::ST_ADV;
				end else
					state_d = tss_pkg::ST_FIRE_CHK;
			end
			tss_pkg::ST_FIRE_CHK: begin
				if (sts.fire_hit) begin
					kind_d = tss_pkg::KIND_FIRED;
					chg_d = 1'b0;
					tagsel_d = 1'b1;
					ret_d = tss_pkg::ST_FIRE_RD;
					state_d = tss_pkg::ST_EMIT;
				end else
					state_d = tss_pkg::ST_FIRE_RD;
			end
			tss_pkg::ST_ADV: begin
				if (!sts.adv_wrap)
					state_d = tss_pkg::ST_STATUS;
				else if (sts.adv_end) begin
					kind_d = tss_pkg::KIND_COMPLETE;
					chg_d = 1'b0;
					tagsel_d = 1'b0;
					ret_d = tss_pkg::ST_STATUS;
					state_d = tss_pkg::ST_EMIT;
				end else begin
					fire_sel_d = 1'b1;
					state_d = tss_pkg::ST_FIRE_RD;
				end
			end
			tss_pkg::ST_EMIT: begin
				if (!sts.out_busy)
					state_d = ret_q;
			end
			tss_pkg::ST_STATUS: begin
				if (!sts.out_busy)
					state_d = tss_pkg::ST_IDLE;
			end
			default: state_d = tss_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			tss_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load_item = in_valid;
			end
			tss_pkg::ST_DECODE: begin
				case (sts.op)
					tss_pkg::OP_ADD_SEG: cmd.add_seg = 1'b1;
					tss_pkg::OP_ADD_EVT: cmd.add_evt_begin = !sts.evt_reject;
					tss_pkg::OP_PLAY: cmd.play = 1'b1;
					tss_pkg::OP_STOP: cmd.stop = 1'b1;
					tss_pkg::OP_SKIP: cmd.skip = 1'b1;
					tss_pkg::OP_TICK: cmd.tick_begin = !sts.tick_idle;
					default: ;
				endcase
			end
			tss_pkg::ST_INS_SCAN: cmd.ins_step = 1'b1;
			tss_pkg::ST_INS_SHIFT: cmd.ins_shift = 1'b1;
			tss_pkg::ST_FIRE_RD: cmd.fire_rd = 1'b1;
			tss_pkg::ST_FIRE_CHK: cmd.fire_mark = 1'b1;
			tss_pkg::ST_ADV: cmd.adv = sts.adv_wrap;
			tss_pkg::ST_EMIT: begin
				cmd.emit = !sts.out_busy;
				cmd.emit_kind = kind_q;
				cmd.emit_chg = chg_q;
				cmd.emit_tag = tagsel_q;
			end
			tss_pkg::ST_STATUS: begin
				cmd.emit = !sts.out_busy;
				cmd.emit_kind = tss_pkg::KIND_STATUS;
				cmd.emit_last = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tss_pkg::ST_IDLE;
			kind_q <= '0;
			chg_q <= 1'b0;
			tagsel_q <= 1'b0;
			ret_q <= tss_pkg::ST_IDLE;
			fire_sel_q <= 1'b0;
		end else begin
			state_q <= state_d;
			kind_q <= kind_d;
			chg_q <= chg_d;
			tagsel_q <= tagsel_d;
			ret_q <= ret_d;
			fire_sel_q <= fire_sel_d;
		end
	end
endmodule
`default_nettype wire

// ----- src/timed_segment_sequencer_core.sv -----
`default_nettype none
// a plain item passes the decode and status states after acceptance, its result item
// registered as status emits; a tick walks each stored event through a fire read and
// a fire check state, closes each walk with a fire read, crosses each segment boundary
// in an advance state and spends an emit state on each result item; one item in flight,
// the next taken when the fsm is back in idle; output stalls hold it in emit or status
// reset: arst_n clears control, counts, flags and fired marks; tables undefined until written
module timed_segment_sequencer_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire tss_pkg::in_item_t in_data,
	output logic out_valid,
	input wire logic out_ready,
	output tss_pkg::out_item_t out_data
);
	// command and status between controller and datapath
	tss_pkg::cmd_t cmd;
	tss_pkg::sts_t sts;

	tss_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sts(sts),
		.cmd(cmd)
	);

	tss_datapath u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.in_item(in_data),
		.cmd(cmd),
		.sts(sts),
		.result(out_data),
		.result_valid(out_valid),
		.result_ready(out_ready)
	);
endmodule
`default_nettype wire

// ----- verif/tss_checker.sv -----
`timescale 1ns / 1ps
module tss_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire tss_pkg::in_item_t in_data,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire tss_pkg::out_item_t out_data,
	output int fail_count,
	output int pending
);
	logic [31:0] seg_dur [tss_pkg::MaxSegments];
	logic [31:0] evt_time [tss_pkg::MaxSegments][tss_pkg::EventsPerSegment];
	logic [15:0] evt_tag [tss_pkg::MaxSegments][tss_pkg::EventsPerSegment];
	logic fired [tss_pkg::MaxSegments][tss_pkg::EventsPerSegment];
	int evt_cnt [tss_pkg::MaxSegments];
	int seg_cnt, cur_seg;
	logic [31:0] seg_time;
	logic playing, complete;
	tss_pkg::out_item_t expected_q[$];

	function automatic void post(logic [2:0] k, int chg, logic [15:0] tag, logic lst);
		tss_pkg::out_item_t o;
		o.kind = k;
		o.changed_index = chg[3:0];
		o.fired_tag = tag;
		o.segment_now = cur_seg[3:0];
		o.time_in_segment = seg_time;
		o.is_playing = playing;
		o.is_complete = complete;
		o.last = lst;
		expected_q.push_back(o);
	endfunction

	function automatic void clear_seg(int s);
		for (int i = 0; i < tss_pkg::EventsPerSegment; i++) fired[s][i] = 1'b0;
	endfunction

	function automatic void fire_due(int s);
		for (int i = 0; i < evt_cnt[s]; i++)
			if (!fired[s][i] && seg_time >= evt_time[s][i]) begin
				fired[s][i] = 1'b1;
				post(tss_pkg::KIND_FIRED, 0, evt_tag[s][i], 1'b0);
			end
	endfunction

	function automatic void predict_item(tss_pkg::in_item_t it);
		int s, n, p, idx;
		logic [31:0] t;
		logic [32:0] sum;
		case (it.operation)
			tss_pkg::OP_ADD_SEG: begin
				if (seg_cnt >= tss_pkg::MaxSegments)
					post(tss_pkg::KIND_REJECTED, 0, 16'd0, 1'b0);
				else begin
					seg_dur[seg_cnt] = (it.time_value == 0) ?
						tss_pkg::MinDurationUs : it.time_value;
					evt_cnt[seg_cnt] = 0;
					clear_seg(seg_cnt);
					seg_cnt++;
				end
			end
			tss_pkg::OP_ADD_EVT: begin
				if (seg_cnt == 0 || evt_cnt[seg_cnt-1] >= tss_pkg::EventsPerSegment)
					post(tss_pkg::KIND_REJECTED, 0, 16'd0, 1'b0);
				else begin
					s = seg_cnt - 1;
					n = evt_cnt[s];
					t = (it.time_value > seg_dur[s]) ? seg_dur[s] : it.time_value;
					p = 0;
					while (p < n && evt_time[s][p] < t) p++;
					for (int i = n; i > p; i--) begin
						evt_time[s][i] = evt_time[s][i-1];
						evt_tag[s][i] = evt_tag[s][i-1];
						fired[s][i] = fired[s][i-1];
					end
					evt_time[s][p] = t;
					evt_tag[s][p] = it.event_tag;
					fired[s][p] = 1'b0;
					evt_cnt[s] = n + 1;
				end
			end
			tss_pkg::OP_PLAY: begin
				if (seg_cnt == 0) complete = 1'b1;
				else begin
					for (int i = 0; i < tss_pkg::MaxSegments; i++) clear_seg(i);
					cur_seg = 0;
					seg_time = 0;
					playing = 1'b1;
					complete = 1'b0;
					post(tss_pkg::KIND_CHANGED, 0, 16'd0, 1'b0);
				end
			end
			tss_pkg::OP_STOP: playing = 1'b0;
			tss_pkg::OP_SKIP: begin
				if (seg_cnt != 0) begin
					idx = int'(it.target_index);
					if (idx < 0) idx = 0;
					if (idx > seg_cnt - 1) idx = seg_cnt - 1;
					cur_seg = idx;
					seg_time = 0;
					playing = 1'b1;
					complete = 1'b0;
					clear_seg(cur_seg);
					post(tss_pkg::KIND_CHANGED, cur_seg, 16'd0, 1'b0);
				end
			end
			tss_pkg::OP_TICK: begin
				if (playing && !complete) begin
					if (cur_seg >= seg_cnt) begin
						complete = 1'b1;
						playing = 1'b0;
					end else begin
						sum = {1'b0, seg_time} + {1'b0, it.time_value};
						seg_time = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
						fire_due(cur_seg);
						while (cur_seg < seg_cnt && seg_time >= seg_dur[cur_seg]) begin
							seg_time -= seg_dur[cur_seg];
							cur_seg++;
							if (cur_seg >= seg_cnt) begin
								playing = 1'b0;
								complete = 1'b1;
								seg_time = 0;
								post(tss_pkg::KIND_COMPLETE, 0, 16'd0, 1'b0);
								break;
							end
							clear_seg(cur_seg);
							fire_due(cur_seg);
							post(tss_pkg::KIND_CHANGED, cur_seg, 16'd0, 1'b0);
						end
					end
				end
			end
			default: ;
		endcase
		post(tss_pkg::KIND_STATUS, 0, 16'd0, 1'b1);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fail_count <= 0;
			pending <= 0;
			expected_q.delete();
			seg_cnt = 0;
			cur_seg = 0;
			seg_time = 0;
			playing = 1'b0;
			complete = 1'b0;
			for (int s = 0; s < tss_pkg::MaxSegments; s++) begin
				evt_cnt[s] = 0;
				clear_seg(s);
			end
		end else begin
			if (in_valid && in_ready) predict_item(in_data);
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result item %p", $time, out_data);
					fail_count <= fail_count + 1;
				end else begin
					if (out_data !== expected_q[0]) begin
						$display("%0t: mismatch expected %p actual %p", $time,
							expected_q[0], out_data);
						fail_count <= fail_count + 1;
					end
					void'(expected_q.pop_front());
				end
			end
			pending <= expected_q.size();
		end
	end
endmodule

// ----- verif/tb_timed_segment_sequencer_core.sv -----
`timescale 1ns / 1ps
module tb_timed_segment_sequencer_core;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	tss_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	tss_pkg::out_item_t out_data;
	int fail_count, pending;
	bit hold_sink = 1'b0;

	always #5 clk = ~clk;

	timed_segment_sequencer_core uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	tss_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.fail_count(fail_count), .pending(pending)
	);

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// offer one item, holding it until accepted; valid stays up for a back-to-back item
	task automatic send_item(logic [2:0] op, logic [31:0] tv, logic [7:0] idx,
			logic [15:0] tag);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		in_data.operation = op;
		in_data.time_value = tv;
		in_data.target_index = idx;
		in_data.event_tag = tag;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [31:0] rand_time();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom();
			default: return $urandom_range(1, 3000);
		endcase
	endfunction

	// sink: random stalls, plus one long hold-off while the source keeps going
	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_sink) begin
				out_ready <= 1'b0;
				repeat (300) @(negedge clk);
				hold_sink = 1'b0;
			end
			g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
			if (g > 0) begin
				out_ready <= 1'b0;
				repeat (g - 1) @(negedge clk);
			end else out_ready <= 1'b1;
		end
	end

	initial begin
		int n;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty-table cases first
		send_item(tss_pkg::OP_ADD_EVT, 32'd5, 8'd0, 16'h1111);
		send_item(tss_pkg::OP_SKIP, 32'd0, 8'd3, 16'h0);
		send_item(tss_pkg::OP_PLAY, 32'd0, 8'd0, 16'h0);
		send_item(tss_pkg::OP_TICK, 32'd10, 8'd0, 16'h0);
		// zero duration, clamp, equal times
		send_item(tss_pkg::OP_ADD_SEG, 32'd0, 8'd0, 16'h0);
		send_item(tss_pkg::OP_ADD_EVT, 32'd5000, 8'd0, 16'hFFFF);
		send_item(tss_pkg::OP_ADD_EVT, 32'd500, 8'd0, 16'hAAAA);
		send_item(tss_pkg::OP_ADD_EVT, 32'd500, 8'd0, 16'h5555);
		send_item(tss_pkg::OP_ADD_EVT, 32'd0, 8'd0, 16'h0001);
		send_item(tss_pkg::OP_ADD_EVT, 32'd1, 8'd0, 16'h0002);
		for (int i = 1; i < tss_pkg::MaxSegments; i++)
			send_item(tss_pkg::OP_ADD_SEG, 32'(100 * i), 8'd0, 16'h0);
		send_item(tss_pkg::OP_ADD_SEG, 32'd7, 8'd0, 16'h0);
		send_item(tss_pkg::OP_PLAY, 32'd0, 8'd0, 16'h0);
		send_item(tss_pkg::OP_TICK, 32'hFFFF_FFFF, 8'd0, 16'h0);
		send_item(tss_pkg::OP_TICK, 32'd1, 8'd0, 16'h0);
		send_item(tss_pkg::OP_SKIP, 32'd0, 8'h80, 16'h0);
		send_item(tss_pkg::OP_SKIP, 32'd0, 8'h7F, 16'h0);
		send_item(tss_pkg::OP_STOP, 32'd0, 8'd0, 16'h0);
		send_item(3'd6, 32'd0, 8'd0, 16'h0);
		send_item(3'd7, 32'd0, 8'd0, 16'h0);

		// random: segment adds, events, play, stop, skip, unknown ops and tick runs over the filled table
		hold_sink = 1'b1;
		n = 0;
		while (n < 454) begin
			case ($urandom_range(0, 19))
				0, 1: send_item(tss_pkg::OP_ADD_SEG, rand_time(), 8'($urandom()),
					16'($urandom()));
				2, 3, 4: send_item(tss_pkg::OP_ADD_EVT, rand_time(), 8'($urandom()),
					16'($urandom()));
				5, 6: send_item(tss_pkg::OP_PLAY, $urandom(), 8'($urandom()),
					16'($urandom()));
				7: send_item(tss_pkg::OP_STOP, $urandom(), 8'($urandom()),
					16'($urandom()));
				8, 9: send_item(tss_pkg::OP_SKIP, $urandom(), 8'($urandom()),
					16'($urandom()));
				10: send_item(3'($urandom_range(6, 7)), $urandom(), 8'($urandom()),
					16'($urandom()));
				11: send_item(tss_pkg::OP_TICK, $urandom(), 8'($urandom()),
					16'($urandom()));
				default: send_item(tss_pkg::OP_TICK, $urandom_range(0, 1500),
					8'($urandom()), 16'($urandom()));
			endcase
			n++;
		end
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#20ms;
		$display("Regression FAIL");
		$finish;
	end
endmodule

// ----- filelist.f -----
src/tss_pkg.sv
src/tss_datapath.sv
src/tss_ctrl.sv
src/timed_segment_sequencer_core.sv
verif/tss_checker.sv
verif/tb_timed_segment_sequencer_core.sv
